// ----- rtl/piecewise_linear_interpolator_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear interpolator
// Each macro checks an implication on the rising edge of clk, with reset
// disabling the check. Defining NO_ASSERTIONS turns every check into nothing.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define PLU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PLU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PLU_ASSERT_NOW(lbl, ante, cons, msg)
`define PLU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/plu_pkg.sv -----
// ----------------------------------------------------------------------------
// Piecewise linear interpolator package
// Field widths, function codes, divider length and sequencer states.
// ----------------------------------------------------------------------------
package plu_pkg;

    localparam int VAL_W     = 32;  // Q16.16 value width
    localparam int CNT_W     = 6;   // point count register width
    localparam int PIDX_W    = 5;   // point index field width
    localparam int DIV_STEPS = 64;  // one quotient bit per step
    localparam int STEP_W    = 6;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_LAST,
        ST_CHK_FIRST,
        ST_SCAN,
        ST_ABS,
        ST_MUL,
        ST_DIV,
        ST_ADJ,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/plu_item_if.sv -----
// ----------------------------------------------------------------------------
// Input item channel
// Carries one write or evaluate item with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface plu_item_if;
    import plu_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    func;
    logic [PIDX_W-1:0]       point_index;
    logic signed [VAL_W-1:0] x_value;
    logic signed [VAL_W-1:0] y_value;

    modport source (output valid, output func, output point_index, output x_value,
                    output y_value, input ready);
    modport sink   (input valid, input func, input point_index, input x_value,
                    input y_value, output ready);
endinterface

// ----- rtl/plu_result_if.sv -----
// ----------------------------------------------------------------------------
// Result item channel
// Carries one interpolated value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface plu_result_if;
    import plu_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;

    modport source (output valid, output result_value, input ready);
    modport sink   (input valid, input result_value, output ready);
endinterface

// ----- rtl/plu_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the point count register write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface plu_cfg_if;
    import plu_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] point_count;

    modport source (output valid, output point_count, input ready);
    modport sink   (input valid, input point_count, output ready);
endinterface

// ----- rtl/piecewise_linear_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// Piecewise linear interpolator unit
// Stores a table of (x, y) breakpoints and evaluates the piecewise linear
// function through them, with a sequential search and a restoring divider.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake      Payload
//  item     in         valid / ready  func, point_index, x_value, y_value
//  result   out        valid / ready  result_value
//  cfg      in         valid / ready  point_count
//
// A write item is stored while the unit stays idle. An evaluate item runs ST_CHK_LAST
// then ST_OUT at or beyond the last breakpoint, adds ST_CHK_FIRST at or below the
// first, and to interpolate adds ST_SCAN (one table read per scan step, 1 to MAX_POINTS-1
// steps), ST_ABS, ST_MUL, 64 ST_DIV steps and ST_ADJ. It takes the next item once the
// result is registered. Reset clears control state only; the table is undefined until
// written. A result waits in the output register; a stalled result holds the unit.
// ----------------------------------------------------------------------------
`include "piecewise_linear_interpolator_unit_assert.svh"

module piecewise_linear_interpolator_unit #(
    parameter int MAX_POINTS = 32
) (
    input logic          clk,
    input logic          rst_n,
    plu_item_if.sink     item,
    plu_result_if.source result,
    plu_cfg_if.sink      cfg
);
    import plu_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CW    = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;

    // Breakpoint table: x in the upper half, y in the lower half.
    logic [2*VAL_W-1:0] mem [MAX_POINTS];
    logic [2*VAL_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               mem_we;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]        point_count_reg, point_count_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]        out_data_reg, out_data_next;
    logic signed [VAL_W-1:0] x_reg, x_next;
    logic signed [VAL_W-1:0] prev_x_reg, prev_x_next;
    logic [VAL_W-1:0]        prev_y_reg, prev_y_next;
    logic [VAL_W-1:0]        num_reg, num_next;
    logic [VAL_W-1:0]        den_reg, den_next;
    logic signed [VAL_W:0]   dy_reg, dy_next;
    logic [VAL_W:0]          mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic [2*VAL_W-1:0]      quo_reg, quo_next;
    logic [VAL_W-1:0]        rem_reg, rem_next;
    logic [VAL_W-1:0]        res_reg, res_next;

    logic                    item_acc;
    logic                    write_ok;
    logic                    out_free;
    logic [CW-1:0]           cnt_ext;
    logic [CW-1:0]           cnt_dec;
    logic [IDX_W-1:0]        last_idx;
    logic signed [VAL_W-1:0] ex;
    logic [VAL_W-1:0]        ey;
    logic                    x_ge;
    logic                    x_le;
    logic                    scan_more;
    logic signed [VAL_W:0]   num_full;
    logic signed [VAL_W:0]   den_full;
    logic signed [VAL_W:0]   dy_full;
    logic [VAL_W:0]          trial;
    logic [VAL_W:0]          trial_diff;
    logic                    trial_fits;
    logic                    step_done;

    assign item_acc = item.valid && item.ready;
    assign write_ok = (32'(item.point_index) < MAX_POINTS);
    assign wr_addr  = IDX_W'(item.point_index);
    assign out_free = !out_valid_reg || result.ready;

    // Clamp the count into 1 .. MAX_POINTS and take the last index in use.
    assign cnt_ext = CW'(point_count_reg);
    assign cnt_dec = cnt_ext - CW'(1);
    always_comb
    begin
        priority if (cnt_ext == '0)
        begin
            last_idx = '0;
        end
        else if (cnt_ext > CW'(MAX_POINTS))
        begin
            last_idx = IDX_W'(MAX_POINTS - 1);
        end
        else
        begin
            last_idx = cnt_dec[IDX_W-1:0];
        end
    end

    assign ex = signed'(rd_data_reg[2*VAL_W-1:VAL_W]);
    assign ey = rd_data_reg[VAL_W-1:0];

    assign x_ge      = (x_reg >= ex);
    assign x_le      = (x_reg <= ex);
    assign scan_more = (idx_reg < last_idx) && (ex < x_reg);

    // Interval differences; the chosen interval keeps x0 < x <= x1.
    assign num_full = (VAL_W+1)'(x_reg) - (VAL_W+1)'(prev_x_reg);
    assign den_full = (VAL_W+1)'(ex) - (VAL_W+1)'(prev_x_reg);
    assign dy_full  = (VAL_W+1)'(signed'(ey)) - (VAL_W+1)'(signed'(prev_y_reg));

    // One restoring division step: the remainder stays below a nonzero divisor.
    assign trial      = {rem_reg, quo_reg[2*VAL_W-1]};
    assign trial_fits = (trial >= {1'b0, den_reg});
    assign trial_diff = trial - {1'b0, den_reg};
    assign step_done  = (step_reg == STEP_W'(DIV_STEPS - 1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {item.x_value, item.y_value};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && item.func == FUNC_EVAL)
                begin
                    state_next = ST_CHK_LAST;
                end
            end
            ST_CHK_LAST:  state_next = x_ge ? ST_OUT : ST_CHK_FIRST;
            ST_CHK_FIRST: state_next = x_le ? ST_OUT : ST_SCAN;
            ST_SCAN:
            begin
                if (!scan_more)
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:       state_next = ST_MUL;
            ST_MUL:       state_next = ST_DIV;
            ST_DIV:
            begin
                if (step_done)
                begin
                    state_next = ST_ADJ;
                end
            end
            ST_ADJ:       state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        item.ready       = (state_reg == ST_IDLE);
        cfg.ready        = (state_reg == ST_IDLE);
        mem_we           = 1'b0;
        rd_addr          = last_idx;
        point_count_next = point_count_reg;
        idx_next         = idx_reg;
        step_next        = step_reg;
        x_next           = x_reg;
        prev_x_next      = prev_x_reg;
        prev_y_next      = prev_y_reg;
        num_next         = num_reg;
        den_next         = den_reg;
        dy_next          = dy_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;

        if (cfg.valid && cfg.ready)
        begin
            point_count_next = cfg.point_count;
        end

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = last_idx;
                if (item_acc)
                begin
                    x_next = item.x_value;
                    mem_we = (item.func == FUNC_WRITE) && write_ok;
                end
            end
            ST_CHK_LAST:
            begin
                rd_addr  = '0;
                res_next = ey;
            end
            ST_CHK_FIRST:
            begin
                rd_addr     = IDX_W'(1);
                res_next    = ey;
                prev_x_next = ex;
                prev_y_next = ey;
                idx_next    = IDX_W'(1);
            end
            ST_SCAN:
            begin
                rd_addr = idx_reg + IDX_W'(1);
                if (scan_more)
                begin
                    prev_x_next = ex;
                    prev_y_next = ey;
                    idx_next    = idx_reg + IDX_W'(1);
                end
                else
                begin
                    num_next = num_full[VAL_W-1:0];
                    den_next = den_full[VAL_W-1:0];
                    dy_next  = dy_full;
                end
            end
            ST_ABS:
            begin
                neg_next = dy_reg[VAL_W];
                mag_next = dy_reg[VAL_W] ? unsigned'(-dy_reg) : unsigned'(dy_reg);
            end
            ST_MUL:
            begin
                quo_next  = (2*VAL_W)'(num_reg) * (2*VAL_W)'(mag_reg);
                rem_next  = '0;
                step_next = '0;
            end
            ST_DIV:
            begin
                rem_next  = trial_fits ? trial_diff[VAL_W-1:0] : trial[VAL_W-1:0];
                quo_next  = {quo_reg[2*VAL_W-2:0], trial_fits};
                step_next = step_reg + STEP_W'(1);
            end
            ST_ADJ:
            begin
                priority if (den_reg == '0)
                begin
                    res_next = prev_y_reg;
                end
                else if (neg_reg)
                begin
                    res_next = prev_y_reg - quo_reg[VAL_W-1:0];
                end
                else
                begin
                    res_next = prev_y_reg + quo_reg[VAL_W-1:0];
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
                rd_addr = last_idx;
            end
        endcase
    end

    assign result.valid        = out_valid_reg;
    assign result.result_value = signed'(out_data_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            point_count_reg <= CNT_W'(1);
            idx_reg         <= '0;
            step_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            point_count_reg <= point_count_next;
            idx_reg         <= idx_next;
            step_reg        <= step_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        prev_x_reg   <= prev_x_next;
        prev_y_reg   <= prev_y_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        dy_reg       <= dy_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    `PLU_ASSERT_NEXT(a_eval_starts, item.valid && item.ready && item.func == FUNC_EVAL, state_reg == ST_CHK_LAST, "evaluate item did not start the search")
    `PLU_ASSERT_NOW(a_result_from_out, $rose(out_valid_reg), $past(state_reg) == ST_OUT, "result appeared outside the output state")
    `PLU_ASSERT_NEXT(a_div_length, state_reg == ST_DIV && step_done, state_reg == ST_ADJ && step_reg == '0, "divider did not finish after its last step")

endmodule
